@@ rtl/core/svs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_pkg
// Shared types and constants for the sorted unique value set.
// ----------------------------------------------------------------------------
package svs_pkg;

    // Default store depth
    localparam int CAPACITY_DEF  = 64;

    // Field widths
    localparam int VALUE_W       = 32;
    localparam int INDEX_W       = 6;
    localparam int FUNC_W        = 3;
    localparam int STATUS_W      = 3;
    localparam int ENTRY_COUNT_W = 7;

    // Stream bus widths (tdata buses in whole bytes)
    localparam int S_TDATA_W     = 72;
    localparam int S_TUSER_W     = 3;
    localparam int M_TDATA_W     = 48;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Operation codes carried in s_tuser
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT  = 3'd0,
        FN_DELETE  = 3'd1,
        FN_REPLACE = 3'd2,
        FN_READ    = 3'd3,
        FN_SET     = 3'd4
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY1,
        S_CMP2,
        S_APPLY2
    } state_t;

    // Per-cell update operation
    typedef enum logic [1:0] {
        COP_NOP,
        COP_INS,
        COP_DEL
    } cell_op_t;

    // Broadcast control from the controller to every cell
    typedef struct packed {
        logic     cmp_en;
        logic     idx_mode;
        cell_op_t op;
    } cell_ctl_t;

endpackage

@@ rtl/core/svs_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_cell
// One slot of the sorted row: holds an entry, compares it against the
// broadcast key or index, and shifts from a neighbor on insert or delete.
// ----------------------------------------------------------------------------
module svs_cell #(
    parameter int CAPACITY = svs_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0
) (
    input  logic                                    aclk,
    input  svs_pkg::cell_ctl_t                      ctl,
    input  svs_pkg::value_t                         key,
    input  logic [((($clog2(CAPACITY+1)) > svs_pkg::INDEX_W) ?
                   ($clog2(CAPACITY+1)) : svs_pkg::INDEX_W)-1:0] bidx,
    input  logic [$clog2(CAPACITY+1)-1:0]           count,
    input  svs_pkg::value_t                         ins_value,
    input  svs_pkg::value_t                         left_value,
    input  logic                                    left_lt,
    input  svs_pkg::value_t                         right_value,
    output svs_pkg::value_t                         value,
    output logic                                    lt,
    output logic                                    eq,
    output svs_pkg::value_t                         rd_value
);
    import svs_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int BIDX_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam logic [BIDX_W-1:0] MY_POS = BIDX_W'(INDEX);

    value_t value_reg, value_next;
    logic   lt_reg, lt_next;
    logic   eq_reg, eq_next;
    logic   valid;

    // Compare against key (value mode) or against position (index mode)
    always_comb begin
        valid = MY_POS < BIDX_W'(count);
        if (ctl.idx_mode) begin
            lt_next = MY_POS < bidx;
            eq_next = MY_POS == bidx;
        end else begin
            lt_next = valid && (value_reg < key);
            eq_next = valid && (value_reg == key);
        end
    end

    // Entry update: cells at or past the slot shift right on insert, left on delete
    always_comb begin
        value_next = value_reg;
        unique case (ctl.op)
            COP_INS: begin
                if (!lt_reg) value_next = left_lt ? ins_value : left_value;
            end
            COP_DEL: begin
                if (!lt_reg) value_next = right_value;
            end
            default: value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (ctl.cmp_en) begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    assign value    = value_reg;
    assign lt       = lt_reg;
    assign eq       = eq_reg;
    assign rd_value = eq_reg ? value_reg : '0;

endmodule

@@ rtl/core/svs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_ctrl
// Operation sequencer: broadcasts compares to the cell row, decides the
// shift, keeps the entry count and drives the result register.
// ----------------------------------------------------------------------------
module svs_ctrl #(
    parameter int CAPACITY = svs_pkg::CAPACITY_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // input transaction
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [svs_pkg::FUNC_W-1:0]              s_func,
    input  svs_pkg::value_t                         s_old_value,
    input  svs_pkg::value_t                         s_new_value,
    input  logic [svs_pkg::INDEX_W-1:0]             s_index,
    // cell row
    input  logic                                    hit,
    input  svs_pkg::value_t                         rd_value,
    output svs_pkg::cell_ctl_t                      ctl,
    output svs_pkg::value_t                         key,
    output logic [((($clog2(CAPACITY+1)) > svs_pkg::INDEX_W) ?
                   ($clog2(CAPACITY+1)) : svs_pkg::INDEX_W)-1:0] bidx,
    output logic [$clog2(CAPACITY+1)-1:0]           count,
    output svs_pkg::value_t                         ins_value,
    // result transaction
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output svs_pkg::value_t                         m_read_value,
    output logic [svs_pkg::ENTRY_COUNT_W-1:0]       m_entry_count,
    output logic [svs_pkg::STATUS_W-1:0]            m_status
);
    import svs_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int BIDX_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int EXT_W  = CNT_W + ENTRY_COUNT_W;

    state_t                   state_reg, state_next;
    logic [FUNC_W-1:0]        func_reg;
    value_t                   new_reg;
    logic [INDEX_W-1:0]       idx_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    value_t                   rd_out_reg;
    logic [ENTRY_COUNT_W-1:0] cnt_out_reg;
    logic [STATUS_W-1:0]      st_out_reg;

    logic                     accept;
    logic                     out_free;
    logic                     in_range;
    logic                     full;
    logic                     need_second;
    logic                     out_load;
    status_t                  out_status;
    value_t                   out_rd;
    logic [EXT_W-1:0]         cnt_ext;

    // Shared decode; no input transaction is taken while in reset
    assign s_tready    = aresetn && (state_reg == S_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign in_range    = BIDX_W'(idx_reg) < BIDX_W'(count_reg);
    assign full        = count_reg == CNT_W'(CAPACITY);
    assign need_second = ((func_reg == FN_REPLACE) && hit) ||
                         ((func_reg == FN_SET) && in_range);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_APPLY1;
            S_APPLY1: begin
                if (need_second)   state_next = S_CMP2;
                else if (out_free) state_next = S_IDLE;
            end
            S_CMP2:   state_next = S_APPLY2;
            S_APPLY2: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // State outputs: cell control, count update, result
    always_comb begin
        ctl.cmp_en   = 1'b0;
        ctl.idx_mode = 1'b0;
        ctl.op       = COP_NOP;
        key          = new_reg;
        bidx         = BIDX_W'(idx_reg);
        count_next   = count_reg;
        out_load     = 1'b0;
        out_status   = ST_OK;
        out_rd       = '0;
        unique case (state_reg)
            S_IDLE: begin
                // first compare goes out with the incoming transaction
                ctl.cmp_en   = accept;
                ctl.idx_mode = (s_func == FN_READ) || (s_func == FN_SET);
                key          = (s_func == FN_INSERT) ? s_new_value : s_old_value;
                bidx         = BIDX_W'(s_index);
            end
            S_APPLY1: begin
                unique case (func_reg)
                    FN_INSERT: begin
                        out_load = out_free;
                        if (hit) begin
                            out_status = ST_DUP;
                        end else if (full) begin
                            out_status = ST_FULL;
                        end else if (out_free) begin
                            ctl.op     = COP_INS;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    FN_DELETE: begin
                        out_load = out_free;
                        if (!hit) begin
                            out_status = ST_NOTFOUND;
                        end else if (out_free) begin
                            ctl.op     = COP_DEL;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    FN_REPLACE: begin
                        if (hit) begin
                            ctl.op     = COP_DEL;
                            count_next = count_reg - CNT_W'(1);
                        end else begin
                            out_load   = out_free;
                            out_status = ST_NOTFOUND;
                        end
                    end
                    FN_READ: begin
                        out_load = out_free;
                        if (in_range) out_rd = rd_value;
                        else          out_status = ST_RANGE;
                    end
                    FN_SET: begin
                        // delete at index, then insert the new value
                        if (in_range) begin
                            ctl.op     = COP_DEL;
                            count_next = count_reg - CNT_W'(1);
                        end else begin
                            out_load   = out_free;
                            out_status = ST_RANGE;
                        end
                    end
                    default: out_load = out_free;
                endcase
            end
            S_CMP2: begin
                ctl.cmp_en = 1'b1;
            end
            S_APPLY2: begin
                out_load = out_free;
                if (hit) begin
                    out_status = ST_DUP;
                end else if (full) begin
                    out_status = ST_FULL;
                end else if (out_free) begin
                    ctl.op     = COP_INS;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign cnt_ext = EXT_W'(count_next);

    // Result valid: set on load, cleared when taken
    always_comb begin
        if (out_load)      m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
        else               m_tvalid_next = m_tvalid_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_func;
            new_reg  <= s_new_value;
            idx_reg  <= s_index;
        end
        if (out_load) begin
            rd_out_reg  <= out_rd;
            cnt_out_reg <= cnt_ext[ENTRY_COUNT_W-1:0];
            st_out_reg  <= out_status;
        end
    end

    assign count         = count_reg;
    assign ins_value     = new_reg;
    assign m_tvalid      = m_tvalid_reg;
    assign m_read_value  = rd_out_reg;
    assign m_entry_count = cnt_out_reg;
    assign m_status      = st_out_reg;

endmodule

@@ rtl/core/sorted_unique_value_set.sv @@
`timescale 1ns / 1ps
// Passes: insert, delete, read and unused codes raise m_tvalid after a pass through
//   the cell row; replace and set by index make a second pass (delete, then insert).
// Flow: one transaction at a time, with s_tready low until the result is loaded;
//   each pass through the cell row is a compare step and then an apply step.
// Reset: aresetn (sync, active low) empties the set and drops m_tvalid; entry
//   storage is not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
// sorted_unique_value_set
// Ascending set of distinct Q16.16 values held in a row of compare/shift cells.
// ----------------------------------------------------------------------------
module sorted_unique_value_set #(
    parameter int CAPACITY = svs_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: old_value[31:0], new_value[63:32], index[69:64], zero pad
    input  logic [svs_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: func[2:0]
    input  logic [svs_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: read_value[31:0], entry_count[38:32], status[41:39], zero pad
    output logic [svs_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);
    import svs_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int BIDX_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int PAD_W  = M_TDATA_W - VALUE_W - ENTRY_COUNT_W - STATUS_W;

    cell_ctl_t                ctl;
    value_t                   key;
    logic [BIDX_W-1:0]        bidx;
    logic [CNT_W-1:0]         count;
    value_t                   ins_value;
    logic                     hit;
    value_t                   rd_value;
    value_t                   m_read_value;
    logic [ENTRY_COUNT_W-1:0] m_entry_count;
    logic [STATUS_W-1:0]      m_status;

    value_t                   cell_value [CAPACITY];
    value_t                   cell_rd    [CAPACITY];
    logic [CAPACITY-1:0]      cell_lt;
    logic [CAPACITY-1:0]      cell_eq;

    svs_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_func        (s_tuser[FUNC_W-1:0]),
        .s_old_value   (s_tdata[VALUE_W-1:0]),
        .s_new_value   (s_tdata[2*VALUE_W-1:VALUE_W]),
        .s_index       (s_tdata[2*VALUE_W+INDEX_W-1:2*VALUE_W]),
        .hit           (hit),
        .rd_value      (rd_value),
        .ctl           (ctl),
        .key           (key),
        .bidx          (bidx),
        .count         (count),
        .ins_value     (ins_value),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_read_value  (m_read_value),
        .m_entry_count (m_entry_count),
        .m_status      (m_status)
    );

    // Cell row: each cell sees its left and right neighbor
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        value_t left_value;
        logic   left_lt;
        value_t right_value;

        if (i == 0) begin : g_first
            assign left_value = ins_value;
            assign left_lt    = 1'b1;
        end else begin : g_mid
            assign left_value = cell_value[i-1];
            assign left_lt    = cell_lt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[i];
        end else begin : g_inner
            assign right_value = cell_value[i+1];
        end

        svs_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .key         (key),
            .bidx        (bidx),
            .count       (count),
            .ins_value   (ins_value),
            .left_value  (left_value),
            .left_lt     (left_lt),
            .right_value (right_value),
            .value       (cell_value[i]),
            .lt          (cell_lt[i]),
            .eq          (cell_eq[i]),
            .rd_value    (cell_rd[i])
        );
    end

    // Match flag and read-out gathered over the row
    assign hit = |cell_eq;

    always_comb begin
        rd_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_value = rd_value | cell_rd[i];
        end
    end

    assign m_tdata = {{PAD_W{1'b0}}, m_status, m_entry_count, m_read_value};

endmodule

@@ rtl/core/svs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svs_checker
// Port-level checks for the sorted unique value set, bound to the top level.
// ----------------------------------------------------------------------------
module svs_checker #(
    parameter int CAPACITY = svs_pkg::CAPACITY_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [svs_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready
);
    import svs_pkg::*;

    logic [ENTRY_COUNT_W-1:0] cnt_f;
    logic [STATUS_W-1:0]      st_f;
    value_t                   rd_f;

    assign rd_f  = m_tdata[VALUE_W-1:0];
    assign cnt_f = m_tdata[VALUE_W+ENTRY_COUNT_W-1:VALUE_W];
    assign st_f  = m_tdata[VALUE_W+ENTRY_COUNT_W+STATUS_W-1:VALUE_W+ENTRY_COUNT_W];

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One transaction in flight: no accept on the following edge
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // Count never passes the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (CAPACITY > 127) || (int'(cnt_f) <= CAPACITY))
        else $error("entry count above capacity");

    // Read value only on a successful operation
    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st_f != ST_OK) |-> rd_f == '0)
        else $error("read value nonzero on failed operation");

endmodule

bind sorted_unique_value_set svs_checker #(
    .CAPACITY (CAPACITY)
) u_svs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
